// ===== src/lvm_pkg.sv =====
// shared types, widths and rounding helpers for the look-at view matrix pipeline
// no dependencies; used by lvm_norm and lookat_view_matrix
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;
  localparam int VEC_W      = 51;
  localparam int MAG_W      = 51;
  localparam int CHUNK_W    = 17;
  localparam int POS_W      = 6;
  localparam int CPOS_W     = 5;
  localparam int NORM_MSB   = 29;
  localparam int A_W        = 30;
  localparam int SQ_W       = 60;
  localparam int SUM_W      = 62;
  localparam int RT_W       = 63;
  localparam int DEN_W      = 31;
  localparam int Q_W        = 17;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = A_W + FRAC_W + 1;
  localparam int UNIT_W     = 18;
  localparam int SIDE_W     = 192;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = Q_W;
  localparam int N_STAGES   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam int WPROD_W = COORD_W + UNIT_W;
  localparam int UPROD_W = 2 * UNIT_W;
  localparam int UC_W    = UPROD_W + 1;
  localparam int DOT_W   = WPROD_W + 2;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]         side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    side_t      side;
  } tag_t;

  // round a Q32 value to signed Q1.16 and clamp to the unit range
  function automatic unit_t unit_round(input logic signed [UC_W-1:0] x);
    logic signed [UC_W:0]      t;
    logic signed [UC_W-FRAC_W:0] r;
    t = $signed({x[UC_W-1], x}) + $signed((UC_W+1)'(32768));
    r = t[UC_W:FRAC_W];
    if (r > $signed((UC_W-FRAC_W+1)'(65536))) begin
      return unit_t'(65536);
    end else if (r < -$signed((UC_W-FRAC_W+1)'(65536))) begin
      return -unit_t'(65536);
    end
    return r[UNIT_W-1:0];
  endfunction

  // negate a Q32 dot product, round to Q16.16 and saturate to 32 bits
  function automatic coord_t shift_round(input logic signed [DOT_W-1:0] dot);
    logic signed [DOT_W+1:0]        t;
    logic signed [DOT_W+1-FRAC_W:0] r;
    t = -$signed({{2{dot[DOT_W-1]}}, dot}) + $signed((DOT_W+2)'(32768));
    r = t[DOT_W+1:FRAC_W];
    if (r > $signed((DOT_W+2-FRAC_W)'(64'sh7fffffff))) begin
      return 32'sh7fffffff;
    end else if (r < $signed((DOT_W+2-FRAC_W)'(-64'sh80000000))) begin
      return 32'sh80000000;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/lvm_norm.sv =====
// pipelined 3-vector normalizer: shift search, sum of squares, bit-serial
// square root and restoring division, one stage per step; uses lvm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lvm_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  lvm_pkg::vec_t       vec [3],
  input  lvm_pkg::side_t      side,
  output logic                out_vld,
  output lvm_pkg::unit_t      unit [3],
  output lvm_pkg::side_t      out_side
);

  logic           vld [lvm_pkg::N_STAGES];
  lvm_pkg::tag_t  tag [lvm_pkg::N_STAGES];
  lvm_pkg::tag_t  tag_in;

  logic [lvm_pkg::MAG_W-1:0]   mag_c [3];
  logic [lvm_pkg::MAG_W-1:0]   mag0 [3];
  logic [lvm_pkg::MAG_W-1:0]   mag1 [3];
  logic [lvm_pkg::MAG_W-1:0]   mag2 [3];
  logic [lvm_pkg::MAG_W-1:0]   orv;
  logic [2:0]                  hit_c;
  logic [lvm_pkg::CPOS_W-1:0]  cpos_c [3];
  logic [2:0]                  hit1;
  logic [lvm_pkg::CPOS_W-1:0]  cpos1 [3];
  logic [lvm_pkg::POS_W-1:0]   pos_c;
  logic [lvm_pkg::POS_W-1:0]   pos2;
  logic [lvm_pkg::A_W-1:0]     a_c [3];
  logic [lvm_pkg::A_W-1:0]     a3 [3];
  logic [lvm_pkg::A_W-1:0]     a4 [3];
  logic [lvm_pkg::SQ_W-1:0]    sq4 [3];

  logic [lvm_pkg::A_W-1:0]     sa   [lvm_pkg::SQRT_STEPS+1][3];
  logic [lvm_pkg::SUM_W-1:0]   srem [lvm_pkg::SQRT_STEPS+1];
  logic [lvm_pkg::RT_W-1:0]    sres [lvm_pkg::SQRT_STEPS+1];

  logic [lvm_pkg::DEN_W-1:0]   dden [lvm_pkg::DIV_STEPS+1];
  logic [lvm_pkg::NUM_W-1:0]   drem [lvm_pkg::DIV_STEPS+1][3];
  logic [lvm_pkg::Q_W-1:0]     dq   [lvm_pkg::DIV_STEPS+1][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][lvm_pkg::VEC_W-1] ? lvm_pkg::MAG_W'(-vec[i])
                                          : lvm_pkg::MAG_W'(vec[i]);
    end
    tag_in.neg  = {vec[2][lvm_pkg::VEC_W-1], vec[1][lvm_pkg::VEC_W-1],
                   vec[0][lvm_pkg::VEC_W-1]};
    tag_in.zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
    tag_in.side = side;
  end

  // valid and tag chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < lvm_pkg::N_STAGES; n++) vld[n] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int n = 1; n < lvm_pkg::N_STAGES; n++) vld[n] <= vld[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= tag_in;
      for (int n = 1; n < lvm_pkg::N_STAGES; n++) tag[n] <= tag[n-1];
    end
  end

  // leading-one search in three chunks, then merge, then shift
  always_comb begin
    orv = mag0[0] | mag0[1] | mag0[2];
    for (int c = 0; c < 3; c++) begin
      hit_c[c]  = 1'b0;
      cpos_c[c] = '0;
      for (int j = 0; j < lvm_pkg::CHUNK_W; j++) begin
        if (orv[c*lvm_pkg::CHUNK_W+j]) begin
          hit_c[c]  = 1'b1;
          cpos_c[c] = lvm_pkg::CPOS_W'(j);
        end
      end
    end
    if (hit1[2]) begin
      pos_c = lvm_pkg::POS_W'(2*lvm_pkg::CHUNK_W) + lvm_pkg::POS_W'(cpos1[2]);
    end else if (hit1[1]) begin
      pos_c = lvm_pkg::POS_W'(lvm_pkg::CHUNK_W) + lvm_pkg::POS_W'(cpos1[1]);
    end else begin
      pos_c = lvm_pkg::POS_W'(cpos1[0]);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos2 >= lvm_pkg::POS_W'(lvm_pkg::NORM_MSB)) begin
        a_c[i] = lvm_pkg::A_W'(mag2[i] >> (pos2 - lvm_pkg::POS_W'(lvm_pkg::NORM_MSB)));
      end else begin
        a_c[i] = lvm_pkg::A_W'(mag2[i] << (lvm_pkg::POS_W'(lvm_pkg::NORM_MSB) - pos2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0  <= mag_c;
      mag1  <= mag0;
      hit1  <= hit_c;
      cpos1 <= cpos_c;
      mag2  <= mag1;
      pos2  <= pos_c;
      a3    <= a_c;
      a4    <= a3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= a3[i] * a3[i];
      end
      sa[0]   <= a4;
      srem[0] <= lvm_pkg::SUM_W'(sq4[0]) + lvm_pkg::SUM_W'(sq4[1])
               + lvm_pkg::SUM_W'(sq4[2]);
      sres[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar g = 0; g < lvm_pkg::SQRT_STEPS; g++) begin : g_sqrt
    logic [lvm_pkg::RT_W-1:0]  bitv;
    logic [lvm_pkg::RT_W-1:0]  trial;
    logic [lvm_pkg::SUM_W-1:0] rem_next;
    logic [lvm_pkg::RT_W-1:0]  res_next;

    always_comb begin
      bitv  = lvm_pkg::RT_W'(1) << (2 * (lvm_pkg::SQRT_STEPS - 1 - g));
      trial = sres[g] + bitv;
      if (lvm_pkg::RT_W'(srem[g]) >= trial) begin
        rem_next = srem[g] - trial[lvm_pkg::SUM_W-1:0];
        res_next = (sres[g] >> 1) + bitv;
      end else begin
        rem_next = srem[g];
        res_next = sres[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa[g+1]   <= sa[g];
        srem[g+1] <= rem_next;
        sres[g+1] <= res_next;
      end
    end
  end

  // numerator with half-divisor rounding
  always_ff @(posedge clk) begin
    if (en) begin
      dden[0] <= sres[lvm_pkg::SQRT_STEPS][lvm_pkg::DEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (lvm_pkg::NUM_W'(sa[lvm_pkg::SQRT_STEPS][i]) << lvm_pkg::FRAC_W)
                    + lvm_pkg::NUM_W'(sres[lvm_pkg::SQRT_STEPS][lvm_pkg::DEN_W-1:1]);
        dq[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < lvm_pkg::DIV_STEPS; g++) begin : g_div
    logic [lvm_pkg::NUM_W:0]   dv;
    logic [lvm_pkg::NUM_W-1:0] rem_next [3];
    logic [lvm_pkg::Q_W-1:0]   q_next [3];

    always_comb begin
      dv = (lvm_pkg::NUM_W+1)'(dden[g]) << (lvm_pkg::DIV_STEPS - 1 - g);
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, drem[g][i]} >= dv) begin
          rem_next[i] = drem[g][i] - dv[lvm_pkg::NUM_W-1:0];
          q_next[i]   = {dq[g][i][lvm_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_next[i] = drem[g][i];
          q_next[i]   = {dq[g][i][lvm_pkg::Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dden[g+1] <= dden[g];
        drem[g+1] <= rem_next;
        dq[g+1]   <= q_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (tag[lvm_pkg::N_STAGES-2].zero) begin
          unit[i] <= '0;
        end else if (tag[lvm_pkg::N_STAGES-2].neg[i]) begin
          unit[i] <= -$signed({1'b0, dq[lvm_pkg::DIV_STEPS][i]});
        end else begin
          unit[i] <= $signed({1'b0, dq[lvm_pkg::DIV_STEPS][i]});
        end
      end
    end
  end

  assign out_vld  = vld[lvm_pkg::N_STAGES-1];
  assign out_side = tag[lvm_pkg::N_STAGES-1].side;

endmodule

`default_nettype wire

// ===== src/lookat_view_matrix.sv =====
// throughput: one pose per cycle; the whole pipeline holds while a result waits
// rst is synchronous and clears all valid bits; data registers are not reset
// top level of the look-at view matrix pipeline; uses lvm_pkg and lvm_norm
`timescale 1ns / 1ps
`default_nettype none

module lookat_view_matrix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    eye_x,
  input  logic signed [31:0]    eye_y,
  input  logic signed [31:0]    eye_z,
  input  logic signed [31:0]    target_x,
  input  logic signed [31:0]    target_y,
  input  logic signed [31:0]    target_z,
  input  logic signed [31:0]    world_up_x,
  input  logic signed [31:0]    world_up_y,
  input  logic signed [31:0]    world_up_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [17:0]    right_x,
  output logic signed [17:0]    right_y,
  output logic signed [17:0]    right_z,
  output logic signed [17:0]    up_x,
  output logic signed [17:0]    up_y,
  output logic signed [17:0]    up_z,
  output logic signed [17:0]    look_x,
  output logic signed [17:0]    look_y,
  output logic signed [17:0]    look_z,
  output logic signed [31:0]    shift_x,
  output logic signed [31:0]    shift_y,
  output logic signed [31:0]    shift_z
);

  logic en;

  // stage a: difference
  logic                                   va;
  lvm_pkg::coord_t                        eye_a [3];
  lvm_pkg::coord_t                        wup_a [3];
  logic signed [lvm_pkg::DIFF_W-1:0]      d_a [3];
  lvm_pkg::vec_t                          n1_vec [3];
  lvm_pkg::side_t                         n1_side_in;

  logic                                   n1_vld;
  lvm_pkg::unit_t                         look1 [3];
  lvm_pkg::side_t                         n1_side;
  lvm_pkg::coord_t                        eye1 [3];
  lvm_pkg::coord_t                        wup1 [3];

  // stages b, c: world up cross look
  logic                                   vb, vc;
  logic signed [lvm_pkg::WPROD_W-1:0]     wp_b [6];
  lvm_pkg::unit_t                         look_b [3];
  lvm_pkg::coord_t                        eye_b [3];
  lvm_pkg::vec_t                          rc_c [3];
  lvm_pkg::side_t                         side_c;

  logic                                   n2_vld;
  lvm_pkg::unit_t                         right2 [3];
  lvm_pkg::side_t                         n2_side;
  lvm_pkg::coord_t                        eye2 [3];
  lvm_pkg::unit_t                         look2 [3];

  // stages d..i: up axis and translations
  logic                                   vd, ve, vf, vg, vh, vi;
  logic signed [lvm_pkg::UPROD_W-1:0]     up_d [6];
  logic signed [lvm_pkg::WPROD_W-1:0]     er_d [3];
  logic signed [lvm_pkg::WPROD_W-1:0]     el_d [3];
  lvm_pkg::unit_t                         right_d [3], look_d [3];
  lvm_pkg::coord_t                        eye_d [3];
  logic signed [lvm_pkg::UC_W-1:0]        uc_e [3];
  logic signed [lvm_pkg::DOT_W-1:0]       dr_e, dl_e;
  lvm_pkg::unit_t                         right_e [3], look_e [3];
  lvm_pkg::coord_t                        eye_e [3];
  lvm_pkg::unit_t                         right_f [3], look_f [3], up_f [3];
  lvm_pkg::coord_t                        eye_f [3];
  lvm_pkg::coord_t                        sx_f, sz_f;
  logic signed [lvm_pkg::WPROD_W-1:0]     eu_g [3];
  lvm_pkg::unit_t                         right_g [3], look_g [3], up_g [3];
  lvm_pkg::coord_t                        sx_g, sz_g;
  logic signed [lvm_pkg::DOT_W-1:0]       du_h;
  lvm_pkg::unit_t                         right_h [3], look_h [3], up_h [3];
  lvm_pkg::coord_t                        sx_h, sz_h;

  assign en       = !vi || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= n1_vld;
      vc <= vb;
      vd <= n2_vld;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_a[0] <= eye_x;
      eye_a[1] <= eye_y;
      eye_a[2] <= eye_z;
      wup_a[0] <= world_up_x;
      wup_a[1] <= world_up_y;
      wup_a[2] <= world_up_z;
      d_a[0]   <= lvm_pkg::DIFF_W'(target_x) - lvm_pkg::DIFF_W'(eye_x);
      d_a[1]   <= lvm_pkg::DIFF_W'(target_y) - lvm_pkg::DIFF_W'(eye_y);
      d_a[2]   <= lvm_pkg::DIFF_W'(target_z) - lvm_pkg::DIFF_W'(eye_z);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_vec[i] = lvm_pkg::VEC_W'(d_a[i]);
    end
    n1_side_in = {eye_a[0], eye_a[1], eye_a[2], wup_a[0], wup_a[1], wup_a[2]};
  end

  lvm_norm u_look_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (va),
    .vec      (n1_vec),
    .side     (n1_side_in),
    .out_vld  (n1_vld),
    .unit     (look1),
    .out_side (n1_side)
  );

  assign {eye1[0], eye1[1], eye1[2], wup1[0], wup1[1], wup1[2]} = n1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      wp_b[0] <= wup1[1] * look1[2];
      wp_b[1] <= wup1[2] * look1[1];
      wp_b[2] <= wup1[2] * look1[0];
      wp_b[3] <= wup1[0] * look1[2];
      wp_b[4] <= wup1[0] * look1[1];
      wp_b[5] <= wup1[1] * look1[0];
      look_b  <= look1;
      eye_b   <= eye1;
      for (int i = 0; i < 3; i++) begin
        rc_c[i] <= lvm_pkg::VEC_W'(wp_b[2*i]) - lvm_pkg::VEC_W'(wp_b[2*i+1]);
      end
      side_c <= {eye_b[0], eye_b[1], eye_b[2], look_b[0], look_b[1], look_b[2],
                 (lvm_pkg::SIDE_W - 3*lvm_pkg::COORD_W - 3*lvm_pkg::UNIT_W)'(0)};
    end
  end

  lvm_norm u_right_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vc),
    .vec      (rc_c),
    .side     (side_c),
    .out_vld  (n2_vld),
    .unit     (right2),
    .out_side (n2_side)
  );

  assign {eye2[0], eye2[1], eye2[2], look2[0], look2[1], look2[2]} =
    n2_side[lvm_pkg::SIDE_W-1 -: 3*lvm_pkg::COORD_W + 3*lvm_pkg::UNIT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      up_d[0] <= look2[1] * right2[2];
      up_d[1] <= look2[2] * right2[1];
      up_d[2] <= look2[2] * right2[0];
      up_d[3] <= look2[0] * right2[2];
      up_d[4] <= look2[0] * right2[1];
      up_d[5] <= look2[1] * right2[0];
      for (int i = 0; i < 3; i++) begin
        er_d[i] <= eye2[i] * right2[i];
        el_d[i] <= eye2[i] * look2[i];
      end
      right_d <= right2;
      look_d  <= look2;
      eye_d   <= eye2;

      for (int i = 0; i < 3; i++) begin
        uc_e[i] <= lvm_pkg::UC_W'(up_d[2*i]) - lvm_pkg::UC_W'(up_d[2*i+1]);
      end
      dr_e    <= lvm_pkg::DOT_W'(er_d[0]) + lvm_pkg::DOT_W'(er_d[1])
               + lvm_pkg::DOT_W'(er_d[2]);
      dl_e    <= lvm_pkg::DOT_W'(el_d[0]) + lvm_pkg::DOT_W'(el_d[1])
               + lvm_pkg::DOT_W'(el_d[2]);
      right_e <= right_d;
      look_e  <= look_d;
      eye_e   <= eye_d;

      for (int i = 0; i < 3; i++) begin
        up_f[i] <= lvm_pkg::unit_round(uc_e[i]);
      end
      sx_f    <= lvm_pkg::shift_round(dr_e);
      sz_f    <= lvm_pkg::shift_round(dl_e);
      right_f <= right_e;
      look_f  <= look_e;
      eye_f   <= eye_e;

      for (int i = 0; i < 3; i++) begin
        eu_g[i] <= eye_f[i] * up_f[i];
      end
      right_g <= right_f;
      look_g  <= look_f;
      up_g    <= up_f;
      sx_g    <= sx_f;
      sz_g    <= sz_f;

      du_h    <= lvm_pkg::DOT_W'(eu_g[0]) + lvm_pkg::DOT_W'(eu_g[1])
               + lvm_pkg::DOT_W'(eu_g[2]);
      right_h <= right_g;
      look_h  <= look_g;
      up_h    <= up_g;
      sx_h    <= sx_g;
      sz_h    <= sz_g;

      right_x <= right_h[0];
      right_y <= right_h[1];
      right_z <= right_h[2];
      up_x    <= up_h[0];
      up_y    <= up_h[1];
      up_z    <= up_h[2];
      look_x  <= look_h[0];
      look_y  <= look_h[1];
      look_z  <= look_h[2];
      shift_x <= sx_h;
      shift_y <= lvm_pkg::shift_round(du_h);
      shift_z <= sz_h;
    end
  end

  assign out_valid = vi;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_look_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (look_x <= 18'sd65536 && look_x >= -18'sd65536 &&
                   right_y <= 18'sd65536 && right_y >= -18'sd65536))
    else $error("axis component out of unit range");

  a_zero_look: assert property (@(posedge clk) disable iff (rst)
    (out_valid && look_x == 0 && look_y == 0 && look_z == 0) |->
    (right_x == 0 && right_y == 0 && right_z == 0 && shift_z == 0))
    else $error("zero look axis with nonzero right axis or translation");

  a_zero_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && right_x == 0 && right_y == 0 && right_z == 0) |->
    (up_x == 0 && up_y == 0 && up_z == 0 && shift_x == 0 && shift_y == 0))
    else $error("zero right axis with nonzero up axis or translation");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (vh == $past(vh) && va == $past(va)))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== tb/lookat_view_matrix_tb.sv =====
// self-checking testbench for lookat_view_matrix: random and directed camera poses,
// predicted in fixed point by a scoreboard class; depends on lvm_pkg and the rtl
`timescale 1ns / 1ps

module lookat_view_matrix_tb;

  typedef longint vec3_t[3];

  typedef struct {
    logic signed [17:0] axis[9];
    logic signed [31:0] shift[3];
  } view_t;

  class pose_scoreboard;
    view_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned isqrt(input longint unsigned s);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > s) bits >>= 2;
      while (bits != 0) begin
        if (s >= res + bits) begin
          s -= res + bits;
          res = (res >> 1) + bits;
        end else begin
          res >>= 1;
        end
        bits >>= 2;
      end
      return res;
    endfunction

    function void unit_vec(input vec3_t v, output vec3_t u);
      longint unsigned a[3], m, s, len;
      int dn, lft;
      m = 0; s = 0; dn = 0; lft = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = v[i] < 0 ? -v[i] : v[i];
        if (a[i] > m) m = a[i];
      end
      if (m == 0) begin
        u = '{0, 0, 0};
        return;
      end
      while (m >= (64'd1 << 30)) begin m >>= 1; dn++; end
      while (m < (64'd1 << 29)) begin m <<= 1; lft++; end
      for (int i = 0; i < 3; i++) begin
        a[i] = (a[i] >> dn) << lft;
        s += a[i] * a[i];
      end
      len = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        longint q;
        q = longint'((a[i] * 65536 + len / 2) / len);
        u[i] = v[i] < 0 ? -q : q;
      end
    endfunction

    function void cross3(input vec3_t a, input vec3_t b, output vec3_t c);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function longint q32_round(input longint x);
      return (x + 32768) >>> 16;
    endfunction

    function longint clip(input longint x, input longint lo, input longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void note(input vec3_t eye, input vec3_t tgt, input vec3_t wup);
      vec3_t d, look, rc, right, uc, upv;
      view_t v;
      longint dot;
      for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
      unit_vec(d, look);
      cross3(wup, look, rc);
      unit_vec(rc, right);
      cross3(look, right, uc);
      for (int i = 0; i < 3; i++) upv[i] = clip(q32_round(uc[i]), -65536, 65536);
      for (int i = 0; i < 3; i++) begin
        v.axis[i] = 18'(right[i]);
        v.axis[3+i] = 18'(upv[i]);
        v.axis[6+i] = 18'(look[i]);
      end
      dot = eye[0] * right[0] + eye[1] * right[1] + eye[2] * right[2];
      v.shift[0] = 32'(clip(q32_round(-dot), -64'sh80000000, 64'sh7fffffff));
      dot = eye[0] * upv[0] + eye[1] * upv[1] + eye[2] * upv[2];
      v.shift[1] = 32'(clip(q32_round(-dot), -64'sh80000000, 64'sh7fffffff));
      dot = eye[0] * look[0] + eye[1] * look[1] + eye[2] * look[2];
      v.shift[2] = 32'(clip(q32_round(-dot), -64'sh80000000, 64'sh7fffffff));
      pending.push_back(v);
    endfunction

    function void check(input view_t got);
      string names[12];
      view_t exp;
      names = '{"right_x", "right_y", "right_z", "up_x", "up_y", "up_z",
                "look_x", "look_y", "look_z", "shift_x", "shift_y", "shift_z"};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
        return;
      end
      exp = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.axis[i] !== exp.axis[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[i], exp.axis[i],
                   got.axis[i]);
          errors++;
        end
      for (int i = 0; i < 3; i++)
        if (got.shift[i] !== exp.shift[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[9+i], exp.shift[i],
                   got.shift[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] eye_x, eye_y, eye_z, target_x, target_y, target_z;
  logic signed [31:0] world_up_x, world_up_y, world_up_z;
  logic signed [17:0] right_x, right_y, right_z, up_x, up_y, up_z, look_x, look_y, look_z;
  logic signed [31:0] shift_x, shift_y, shift_z;

  pose_scoreboard sb = new();
  bit quiet = 0;
  int stuck = 0;

  lookat_view_matrix DUT (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    view_t got;
    if (rst) begin
      stuck <= 0;
    end else begin
      if (in_valid && in_ready)
        sb.note('{eye_x, eye_y, eye_z}, '{target_x, target_y, target_z},
                '{world_up_x, world_up_y, world_up_z});
      if (out_valid && out_ready) begin
        got.axis = '{right_x, right_y, right_z, up_x, up_y, up_z, look_x, look_y, look_z};
        got.shift = '{shift_x, shift_y, shift_z};
        sb.check(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (stuck >= 5000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_pose(input vec3_t e, input vec3_t t, input vec3_t w);
    in_valid <= 1'b1;
    eye_x <= 32'(e[0]); eye_y <= 32'(e[1]); eye_z <= 32'(e[2]);
    target_x <= 32'(t[0]); target_y <= 32'(t[1]); target_z <= 32'(t[2]);
    world_up_x <= 32'(w[0]); world_up_y <= 32'(w[1]); world_up_z <= 32'(w[2]);
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic longint any_coord(input int mode);
    case (mode)
      0: return longint'($signed($urandom));
      1: return longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      2: return longint'($urandom_range(0, 1 << 26)) - (1 << 25);
      default: return longint'($signed($urandom)) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic random_pose();
    vec3_t e, t, w;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      e[i] = any_coord(mode);
      t[i] = any_coord($urandom_range(0, 3));
      w[i] = any_coord($urandom_range(0, 3));
    end
    case ($urandom_range(0, 9))
      0: t = e;
      1: for (int i = 0; i < 3; i++) w[i] = (t[i] - e[i]) >>> 1;
      2: w = '{0, 0, 0};
      3, 4: w = '{0, 65536, 0};
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      e[i] = longint'(32'(e[i])) <<< 32 >>> 32;
      t[i] = longint'(32'(t[i])) <<< 32 >>> 32;
      w[i] = longint'(32'(w[i])) <<< 32 >>> 32;
    end
    send_pose(e, t, w);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    longint mx, mn;
    mx = 64'sh7fffffff;
    mn = -64'sh80000000;
    rst <= 1'b1;
    in_valid <= 1'b0;
    {eye_x, eye_y, eye_z, target_x, target_y, target_z} <= '0;
    {world_up_x, world_up_y, world_up_z} <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // eye equals target, zero up, parallel up, extremes, translation overflow
    send_pose('{0, 0, 0}, '{0, 0, 65536}, '{0, 65536, 0});
    send_pose('{65536, 131072, -65536}, '{65536, 131072, -65536}, '{0, 65536, 0});
    send_pose('{mx, mn, mx}, '{mx, mn, mx}, '{mx, mx, mx});
    send_pose('{0, 0, 0}, '{0, 0, 65536}, '{0, 0, 0});
    send_pose('{0, 0, 0}, '{0, 0, 65536}, '{0, 0, 131072});
    send_pose('{0, 0, 0}, '{0, 0, 65536}, '{0, 0, -65536});
    send_pose('{mx, mx, mx}, '{0, 0, 0}, '{0, 65536, 0});
    send_pose('{mn, mn, mn}, '{0, 0, 0}, '{0, 65536, 0});
    send_pose('{mn, mn, mn}, '{mx, mx, mx}, '{mn, mx, mn});
    send_pose('{mx, mx, mx}, '{mn, mn, mn}, '{mx, mn, mx});
    send_pose('{mx, 0, mn}, '{mn, mx, 0}, '{mn, mn, mx});
    send_pose('{mn, mx, 0}, '{mx, mn, mx}, '{mx, mx, mn});
    send_pose('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0});
    send_pose('{-1, -1, -1}, '{0, 0, 0}, '{1, 0, 0});
    send_pose('{mx, mx, 0}, '{mx, mn, 0}, '{0, 0, 65536});
    send_pose('{-65536, 0, 0}, '{65536, 65536, 65536}, '{mn, 0, 0});
    send_pose('{mn, 0, 0}, '{0, 0, 0}, '{0, mn, 0});
    send_pose('{0, mn, 0}, '{0, 0, 0}, '{0, 0, mn});
    send_pose('{12345678, -87654321, 55555}, '{-7, 3, 1}, '{1, 65536, -2});

    for (int n = 0; n < 650; n++) begin
      if (n == 300) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (n == 550) quiet = 1;
      random_pose();
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lvm_pkg.sv
src/lvm_norm.sv
src/lookat_view_matrix.sv
tb/lookat_view_matrix_tb.sv
